[hw/rtl/twtt_pkg.sv]
// shared types, codes and score helpers for the two-way transposition table
// no dependencies; imported by twtt_ctrl, twtt_dp and two_way_transposition_table
package twtt_pkg;

  // sizing defaults for the top-level parameters
  localparam int unsigned BucketIndexBitsDef = 10;
  localparam int unsigned MoveBitsDef        = 16;

  // fixed field widths
  localparam int unsigned KeyW       = 64;
  localparam int unsigned ScoreW     = 21;
  localparam int unsigned DepthW     = 8;
  localparam int unsigned PlyW       = 8;
  localparam int unsigned InMoveW    = 16;
  localparam int unsigned FoundMoveW = 16;
  localparam int unsigned CountW     = 32;

  typedef logic signed [ScoreW-1:0] score_t;
  typedef logic signed [ScoreW+1:0] wide_score_t;

  // mate window and score saturation limits
  localparam wide_score_t MateHi  = 23'sd900000;
  localparam wide_score_t MateLo  = -23'sd900000;
  localparam wide_score_t ScoreHi = 23'sd1048575;
  localparam wide_score_t ScoreLo = -23'sd1048575;

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_STORE = 2'd1,
    KIND_CLEAR = 2'd2
  } twtt_kind_e;

  typedef enum logic [1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2
  } twtt_bound_e;

  typedef enum logic [1:0] {
    OUT_MISS   = 2'd0,
    OUT_HIT    = 2'd1,
    OUT_CUTOFF = 2'd2,
    OUT_DONE   = 2'd3
  } twtt_outcome_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_WIPE,
    ST_DONE
  } twtt_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the input word, launch the bucket read
    logic look;       // register way match and score adjust
    logic finish;     // write back, bump counters, load the result word
    logic wipe_step;  // zero one bucket row
  } twtt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic wipe_last;    // the row being zeroed is the last one
    logic out_blocked;  // result register still holds an untaken word
  } twtt_stat_t;

  function automatic score_t sat_score(input wide_score_t v);
    wide_score_t r;
    r = v;
    if (v > ScoreHi) begin
      r = ScoreHi;
    end else if (v < ScoreLo) begin
      r = ScoreLo;
    end
    return score_t'(r);
  endfunction

  // to_table: push mate scores away from zero by ply, else pull them back
  function automatic score_t mate_adjust(input score_t s, input logic [PlyW-1:0] ply,
                                         input logic to_table);
    wide_score_t w;
    wide_score_t p;
    wide_score_t r;
    w = wide_score_t'(s);
    p = {15'd0, ply};
    r = w;
    if (w > MateHi) begin
      r = to_table ? w + p : w - p;
    end else if (w < MateLo) begin
      r = to_table ? w - p : w + p;
    end
    return sat_score(r);
  endfunction

endpackage

[hw/rtl/two_way_transposition_table.sv]
// top level of the two-way bucket transposition table (always replace)
// depends on twtt_pkg, twtt_ctrl, twtt_dp
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_stall_o  kind, key, search_depth, alpha, beta,
//                                             ply, entry_score, bound_type, entry_move
//  out      output     out_valid_o/out_stall_i outcome, found_score, found_move,
//                                             probe/hit/cutoff/store counts
//
// probe and store run as a bucket read, way compare with mate adjust,
//   then cutoff test with write back into the single-port bucket memory
// clear zeroes all 2^BUCKET_INDEX_BITS rows, one bucket row per cycle
// after reset a clearing pass over 2^BUCKET_INDEX_BITS rows (1024 by default)
//   runs with in_stall_o high
// a finished word sits in the result register; the next word is accepted meanwhile
//   and waits at its last step only while out_stall_i holds the previous result
module two_way_transposition_table #(
  parameter int unsigned BUCKET_INDEX_BITS = twtt_pkg::BucketIndexBitsDef,
  parameter int unsigned MOVE_BITS         = twtt_pkg::MoveBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         kind_i,
  input  logic [twtt_pkg::KeyW-1:0]          key_i,
  input  logic [twtt_pkg::DepthW-1:0]        search_depth_i,
  input  logic signed [twtt_pkg::ScoreW-1:0] alpha_i,
  input  logic signed [twtt_pkg::ScoreW-1:0] beta_i,
  input  logic [twtt_pkg::PlyW-1:0]          ply_i,
  input  logic signed [twtt_pkg::ScoreW-1:0] entry_score_i,
  input  logic [1:0]                         bound_type_i,
  input  logic [twtt_pkg::InMoveW-1:0]       entry_move_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         outcome_o,
  output logic signed [twtt_pkg::ScoreW-1:0] found_score_o,
  output logic [twtt_pkg::FoundMoveW-1:0]    found_move_o,
  output logic [twtt_pkg::CountW-1:0]        probe_count_o,
  output logic [twtt_pkg::CountW-1:0]        hit_count_o,
  output logic [twtt_pkg::CountW-1:0]        cutoff_count_o,
  output logic [twtt_pkg::CountW-1:0]        store_count_o
);
  import twtt_pkg::*;

  // command and status between sequencer and datapath
  twtt_cmd_t  cmd;
  twtt_stat_t stat;

  // sequencer: owns the input handshake and steps the datapath
  twtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: bucket memory rows hold both ways so a store shifts way 0
  // into way 1 with a single read-modify-write of one row
  twtt_dp #(
    .BucketIndexBits (BUCKET_INDEX_BITS),
    .MoveBits        (MOVE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (kind_i),
    .key_i          (key_i),
    .search_depth_i (search_depth_i),
    .alpha_i        (alpha_i),
    .beta_i         (beta_i),
    .ply_i          (ply_i),
    .entry_score_i  (entry_score_i),
    .bound_type_i   (bound_type_i),
    .entry_move_i   (entry_move_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .outcome_o      (outcome_o),
    .found_score_o  (found_score_o),
    .found_move_o   (found_move_o),
    .probe_count_o  (probe_count_o),
    .hit_count_o    (hit_count_o),
    .cutoff_count_o (cutoff_count_o),
    .store_count_o  (store_count_o)
  );

endmodule

[hw/rtl/twtt_ctrl.sv]
// sequencing state machine: reset wipe, lookup, finish and clear walk
// depends on twtt_pkg
module twtt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             kind_i,
  output logic                   in_stall_o,
  input  twtt_pkg::twtt_stat_t   stat_i,
  output twtt_pkg::twtt_cmd_t    cmd_o
);
  import twtt_pkg::*;

  twtt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (stat_i.wipe_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (kind_i == KIND_CLEAR) ? ST_WIPE : ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_DONE;
      ST_WIPE: begin
        if (stat_i.wipe_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!stat_i.out_blocked) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_INIT: cmd_o.wipe_step = 1'b1;
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_LOOK: cmd_o.look = 1'b1;
      ST_WIPE: cmd_o.wipe_step = 1'b1;
      ST_DONE: cmd_o.finish = !stat_i.out_blocked;
      default: cmd_o = '0;
    endcase
  end

  a_capture_leads_to_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_LOOK) || (state_q == ST_WIPE))
    else $error("capture not followed by lookup or clear walk");

  a_finish_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == ST_IDLE) && !in_stall_o)
    else $error("finish did not reopen the input");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

endmodule

[hw/rtl/twtt_dp.sv]
// datapath: bucket memory, way compare, mate adjust, counters, result register
// depends on twtt_pkg
module twtt_dp #(
  parameter int unsigned BucketIndexBits = twtt_pkg::BucketIndexBitsDef,
  parameter int unsigned MoveBits        = twtt_pkg::MoveBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  twtt_pkg::twtt_cmd_t                cmd_i,
  output twtt_pkg::twtt_stat_t               stat_o,
  input  logic [1:0]                         kind_i,
  input  logic [twtt_pkg::KeyW-1:0]          key_i,
  input  logic [twtt_pkg::DepthW-1:0]        search_depth_i,
  input  logic signed [twtt_pkg::ScoreW-1:0] alpha_i,
  input  logic signed [twtt_pkg::ScoreW-1:0] beta_i,
  input  logic [twtt_pkg::PlyW-1:0]          ply_i,
  input  logic signed [twtt_pkg::ScoreW-1:0] entry_score_i,
  input  logic [1:0]                         bound_type_i,
  input  logic [twtt_pkg::InMoveW-1:0]       entry_move_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         outcome_o,
  output logic signed [twtt_pkg::ScoreW-1:0] found_score_o,
  output logic [twtt_pkg::FoundMoveW-1:0]    found_move_o,
  output logic [twtt_pkg::CountW-1:0]        probe_count_o,
  output logic [twtt_pkg::CountW-1:0]        hit_count_o,
  output logic [twtt_pkg::CountW-1:0]        cutoff_count_o,
  output logic [twtt_pkg::CountW-1:0]        store_count_o
);
  import twtt_pkg::*;

  localparam int unsigned Rows = 1 << BucketIndexBits;

  typedef struct packed {
    logic [KeyW-1:0]     key;
    score_t              score;
    logic [MoveBits-1:0] move;
    logic [DepthW-1:0]   depth;
    logic [1:0]          btype;
  } way_t;

  typedef struct packed {
    way_t w1;
    way_t w0;
  } row_t;

  // captured request word
  logic [1:0]         kind_q;
  logic [KeyW-1:0]    key_q;
  logic [DepthW-1:0]  depth_q;
  score_t             alpha_q, beta_q, escore_q;
  logic [PlyW-1:0]    ply_q;
  logic [1:0]         btype_q;
  logic [InMoveW-1:0] emove_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      key_q    <= key_i;
      depth_q  <= search_depth_i;
      alpha_q  <= alpha_i;
      beta_q   <= beta_i;
      ply_q    <= ply_i;
      escore_q <= entry_score_i;
      btype_q  <= bound_type_i;
      emove_q  <= entry_move_i;
    end
  end

  // bucket memory, one row per bucket
  row_t                       bucket_mem_q [Rows];
  row_t                       rd_row_q;
  row_t                       wr_row;
  logic                       wr_en;
  logic [BucketIndexBits-1:0] wr_addr;
  logic [BucketIndexBits-1:0] wipe_cnt_q;
  logic                       key_nz;
  way_t                       new_way;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_row_q <= bucket_mem_q[key_i[BucketIndexBits-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bucket_mem_q[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_cnt_q <= '0;
    end else if (cmd_i.wipe_step) begin
      wipe_cnt_q <= wipe_cnt_q + 1'b1;
    end
  end

  // lookup stage
  logic   hit0, hit1;
  way_t   sel_way;
  logic   hit_q;
  way_t   cand_q;
  score_t cand_score_q;
  score_t new_score_q;

  assign key_nz  = (key_q != '0);
  assign hit0    = key_nz && (rd_row_q.w0.key == key_q);
  assign hit1    = key_nz && (rd_row_q.w1.key == key_q);
  assign sel_way = hit0 ? rd_row_q.w0 : rd_row_q.w1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      hit_q        <= hit0 || hit1;
      cand_q       <= sel_way;
      cand_score_q <= mate_adjust(sel_way.score, ply_q, 1'b0);
      new_score_q  <= mate_adjust(escore_q, ply_q, 1'b1);
    end
  end

  // finish stage
  logic                  is_probe, is_store, is_clear;
  logic                  cut;
  logic                  do_store;
  logic [1:0]            outcome_d;
  score_t                fscore_d;
  logic [FoundMoveW-1:0] fmove_d;
  logic [31:0]           move_ext;

  assign is_probe = (kind_q == KIND_PROBE);
  assign is_store = (kind_q == KIND_STORE);
  assign is_clear = (kind_q == KIND_CLEAR);
  assign do_store = cmd_i.finish && is_store && key_nz;

  always_comb begin
    cut = 1'b0;
    if (cand_q.depth >= depth_q) begin
      case (cand_q.btype)
        BOUND_EXACT: cut = 1'b1;
        BOUND_LOWER: cut = (cand_score_q >= beta_q);
        BOUND_UPPER: cut = (cand_score_q <= alpha_q);
        default:     cut = 1'b0;
      endcase
    end
  end

  assign move_ext = 32'(cand_q.move);

  always_comb begin
    outcome_d = OUT_MISS;
    fscore_d  = '0;
    fmove_d   = '0;
    if (is_probe && hit_q) begin
      fmove_d   = move_ext[FoundMoveW-1:0];
      outcome_d = cut ? OUT_CUTOFF : OUT_HIT;
      if (cut) fscore_d = cand_score_q;
    end else if ((is_store && key_nz) || is_clear) begin
      outcome_d = OUT_DONE;
    end
  end

  assign new_way.key   = key_q;
  assign new_way.score = new_score_q;
  assign new_way.move  = MoveBits'(emove_q);
  assign new_way.depth = depth_q;
  assign new_way.btype = btype_q;

  always_comb begin
    if (cmd_i.wipe_step) begin
      wr_row  = '0;
      wr_addr = wipe_cnt_q;
    end else begin
      wr_row.w1 = rd_row_q.w0;
      wr_row.w0 = new_way;
      wr_addr   = key_q[BucketIndexBits-1:0];
    end
  end
  assign wr_en = cmd_i.wipe_step || do_store;

  // counters
  logic [CountW-1:0] probe_cnt_q, hit_cnt_q, cut_cnt_q, store_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_cnt_q <= '0;
      hit_cnt_q   <= '0;
      cut_cnt_q   <= '0;
      store_cnt_q <= '0;
    end else if (cmd_i.finish) begin
      if (is_clear) begin
        probe_cnt_q <= '0;
        hit_cnt_q   <= '0;
        cut_cnt_q   <= '0;
        store_cnt_q <= '0;
      end else if (is_probe) begin
        probe_cnt_q <= probe_cnt_q + 1'b1;
        if (hit_q) hit_cnt_q <= hit_cnt_q + 1'b1;
        if (hit_q && cut) cut_cnt_q <= cut_cnt_q + 1'b1;
      end else if (is_store && key_nz) begin
        store_cnt_q <= store_cnt_q + 1'b1;
      end
    end
  end

  // result register
  logic                  out_valid_q;
  logic [1:0]            outcome_q;
  score_t                fscore_q;
  logic [FoundMoveW-1:0] fmove_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      outcome_q <= outcome_d;
      fscore_q  <= fscore_d;
      fmove_q   <= fmove_d;
    end
  end

  assign stat_o.wipe_last   = &wipe_cnt_q;
  assign stat_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign outcome_o      = outcome_q;
  assign found_score_o  = fscore_q;
  assign found_move_o   = fmove_q;
  assign probe_count_o  = probe_cnt_q;
  assign hit_count_o    = hit_cnt_q;
  assign cutoff_count_o = cut_cnt_q;
  assign store_count_o  = store_cnt_q;

  a_no_read_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && cmd_i.capture))
    else $error("bucket read and write in the same cycle");

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten before it was taken");

  a_probe_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && is_probe) |=> probe_cnt_q == $past(probe_cnt_q) + 32'd1)
    else $error("probe not counted");

  a_cut_implies_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && outcome_d == OUT_CUTOFF) |-> (hit_q && is_probe))
    else $error("cutoff without a matching way");

endmodule

[tb/twtt_checker.sv]
// result checker for the two-way transposition table: watches both channels,
// keeps its own copy of the buckets and counters and compares every result word
// depends on twtt_pkg
module twtt_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [1:0]                         kind_i,
  input  logic [twtt_pkg::KeyW-1:0]          key_i,
  input  logic [twtt_pkg::DepthW-1:0]        search_depth_i,
  input  logic signed [twtt_pkg::ScoreW-1:0] alpha_i,
  input  logic signed [twtt_pkg::ScoreW-1:0] beta_i,
  input  logic [twtt_pkg::PlyW-1:0]          ply_i,
  input  logic signed [twtt_pkg::ScoreW-1:0] entry_score_i,
  input  logic [1:0]                         bound_type_i,
  input  logic [twtt_pkg::InMoveW-1:0]       entry_move_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [1:0]                         outcome_i,
  input  logic signed [twtt_pkg::ScoreW-1:0] found_score_i,
  input  logic [twtt_pkg::FoundMoveW-1:0]    found_move_i,
  input  logic [twtt_pkg::CountW-1:0]        probe_count_i,
  input  logic [twtt_pkg::CountW-1:0]        hit_count_i,
  input  logic [twtt_pkg::CountW-1:0]        cutoff_count_i,
  input  logic [twtt_pkg::CountW-1:0]        store_count_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import twtt_pkg::*;

  localparam int Entries  = 2 << BucketIndexBitsDef;
  localparam int MateEdge = 900000;
  localparam int ScoreTop = 1048575;

  typedef struct {
    logic [1:0]               outcome;
    logic signed [ScoreW-1:0] score;
    logic [FoundMoveW-1:0]    move;
    logic [CountW-1:0]        probes;
    logic [CountW-1:0]        hits;
    logic [CountW-1:0]        cutoffs;
    logic [CountW-1:0]        stores;
  } table_reply_t;

  logic [KeyW-1:0]    tag_mem   [Entries];
  int                 score_mem [Entries];
  logic [InMoveW-1:0] move_mem  [Entries];
  logic [DepthW-1:0]  depth_mem [Entries];
  logic [1:0]         bound_mem [Entries];
  logic [CountW-1:0]  probe_tally, hit_tally, cutoff_tally, store_tally;

  table_reply_t replies_due[$];
  table_reply_t fresh, due;

  function automatic int clamp_score(input int s);
    if (s > ScoreTop) return ScoreTop;
    if (s < -ScoreTop) return -ScoreTop;
    return s;
  endfunction

  // ply_step is +ply going into the table and -ply coming out
  function automatic int mate_shift(input int s, input int ply_step);
    if (s > MateEdge) begin
      s = s + ply_step;
    end else if (s < -MateEdge) begin
      s = s - ply_step;
    end
    return clamp_score(s);
  endfunction

  task automatic wipe_table();
    for (int e = 0; e < Entries; e++) begin
      tag_mem[e]   = '0;
      score_mem[e] = 0;
      move_mem[e]  = '0;
      depth_mem[e] = '0;
      bound_mem[e] = '0;
    end
    probe_tally  = '0;
    hit_tally    = '0;
    cutoff_tally = '0;
    store_tally  = '0;
  endtask

  // apply one accepted word to the table copy and build the reply it should get
  task automatic serve_request(output table_reply_t r);
    int  row;
    int  s;
    bit  matched;
    bit  cut;
    r.outcome = OUT_MISS;
    r.score   = '0;
    r.move    = '0;
    matched   = 1'b0;
    row       = 2 * int'(key_i[BucketIndexBitsDef-1:0]);
    case (kind_i)
      KIND_PROBE: begin
        probe_tally++;
        for (int w = 0; w < 2; w++) begin
          if (!matched && key_i != '0 && tag_mem[row+w] == key_i) begin
            matched = 1'b1;
            hit_tally++;
            r.outcome = OUT_HIT;
            r.move    = move_mem[row+w];
            if (depth_mem[row+w] >= search_depth_i) begin
              s   = mate_shift(score_mem[row+w], -int'(ply_i));
              cut = (bound_mem[row+w] == BOUND_EXACT) ||
                    (bound_mem[row+w] == BOUND_LOWER && s >= int'(beta_i)) ||
                    (bound_mem[row+w] == BOUND_UPPER && s <= int'(alpha_i));
              if (cut) begin
                cutoff_tally++;
                r.outcome = OUT_CUTOFF;
                r.score   = ScoreW'(s);
              end
            end
          end
        end
      end
      KIND_STORE: begin
        // zero keys are neither stored nor counted; the reply stays a miss
        if (key_i != '0) begin
          store_tally++;
          tag_mem[row+1]   = tag_mem[row];
          score_mem[row+1] = score_mem[row];
          move_mem[row+1]  = move_mem[row];
          depth_mem[row+1] = depth_mem[row];
          bound_mem[row+1] = bound_mem[row];
          tag_mem[row]     = key_i;
          score_mem[row]   = mate_shift(clamp_score(int'(entry_score_i)), int'(ply_i));
          move_mem[row]    = entry_move_i;
          depth_mem[row]   = search_depth_i;
          bound_mem[row]   = bound_type_i;
          r.outcome = OUT_DONE;
        end
      end
      KIND_CLEAR: begin
        wipe_table();
        r.outcome = OUT_DONE;
      end
      default: begin
      end
    endcase
    r.probes  = probe_tally;
    r.hits    = hit_tally;
    r.cutoffs = cutoff_tally;
    r.stores  = store_tally;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_table();
      replies_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result word with nothing pending: outcome %0d", $realtime,
                     outcome_i);
          end
        end else begin
          due = replies_due.pop_front();
          if (outcome_i !== due.outcome || found_score_i !== due.score ||
              found_move_i !== due.move || probe_count_i !== due.probes ||
              hit_count_i !== due.hits || cutoff_count_i !== due.cutoffs ||
              store_count_i !== due.stores) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: mismatch expected outcome %0d score %0d move %h counts %0d/%0d/%0d/%0d",
                       $realtime, due.outcome, due.score, due.move, due.probes, due.hits,
                       due.cutoffs, due.stores);
              $display("%0t:            got outcome %0d score %0d move %h counts %0d/%0d/%0d/%0d",
                       $realtime, outcome_i, found_score_i, found_move_i, probe_count_i,
                       hit_count_i, cutoff_count_i, store_count_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        serve_request(fresh);
        replies_due.push_back(fresh);
      end
      pending_o = replies_due.size();
    end
  end

endmodule

[tb/tb.sv]
// top of the transposition table testbench: clock, reset, request stimulus and
// result stall pattern; checking is done by twtt_checker
// depends on twtt_pkg, two_way_transposition_table, twtt_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twtt_pkg::*;

  // codes the package has no name for
  localparam logic [1:0] KindUnused  = 2'd3;
  localparam logic [1:0] BoundUnused = 2'd3;

  localparam int RandomWords = 1150;
  localparam int PoolSize    = 24;
  localparam int HotRows     = 6;

  // directed keys: A, B and C share the top bucket, D, E and F share bucket zero
  localparam logic [KeyW-1:0] KeyA = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [KeyW-1:0] KeyB = 64'h0000_0000_0000_03FF;
  localparam logic [KeyW-1:0] KeyC = 64'h8000_0000_0000_03FF;
  localparam logic [KeyW-1:0] KeyD = 64'h0000_0001_0000_0000;
  localparam logic [KeyW-1:0] KeyE = 64'h7FFF_FFFF_0000_0000;
  localparam logic [KeyW-1:0] KeyF = 64'h0123_4567_89AB_C000;

  typedef struct {
    logic [1:0]               kind;
    logic [KeyW-1:0]          key;
    logic [DepthW-1:0]        depth;
    logic signed [ScoreW-1:0] alpha;
    logic signed [ScoreW-1:0] beta;
    logic [PlyW-1:0]          ply;
    logic signed [ScoreW-1:0] score;
    logic [1:0]               bound;
    logic [InMoveW-1:0]       move;
  } request_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // request channel, all known from time zero
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [1:0]               req_kind  = '0;
  logic [KeyW-1:0]          req_key   = '0;
  logic [DepthW-1:0]        req_depth = '0;
  logic signed [ScoreW-1:0] req_alpha = '0;
  logic signed [ScoreW-1:0] req_beta  = '0;
  logic [PlyW-1:0]          req_ply   = '0;
  logic signed [ScoreW-1:0] req_score = '0;
  logic [1:0]               req_bound = '0;
  logic [InMoveW-1:0]       req_move  = '0;

  // result channel
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               outcome;
  logic signed [ScoreW-1:0] found_score;
  logic [FoundMoveW-1:0]    found_move;
  logic [CountW-1:0]        probe_count, hit_count, cutoff_count, store_count;

  int fail_count;
  int pending_count;

  // sender burst state and receiver stall pattern state
  int burst_left     = 3;
  int stall_mode     = 0;
  int stall_mode_len = 0;

  logic [KeyW-1:0]              key_pool [PoolSize];
  logic [BucketIndexBitsDef-1:0] hot_rows [HotRows];

  always #2 clk = ~clk;

  two_way_transposition_table i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (req_kind),
    .key_i         (req_key),
    .search_depth_i(req_depth),
    .alpha_i       (req_alpha),
    .beta_i        (req_beta),
    .ply_i         (req_ply),
    .entry_score_i (req_score),
    .bound_type_i  (req_bound),
    .entry_move_i  (req_move),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .outcome_o     (outcome),
    .found_score_o (found_score),
    .found_move_o  (found_move),
    .probe_count_o (probe_count),
    .hit_count_o   (hit_count),
    .cutoff_count_o(cutoff_count),
    .store_count_o (store_count)
  );

  twtt_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .kind_i        (req_kind),
    .key_i         (req_key),
    .search_depth_i(req_depth),
    .alpha_i       (req_alpha),
    .beta_i        (req_beta),
    .ply_i         (req_ply),
    .entry_score_i (req_score),
    .bound_type_i  (req_bound),
    .entry_move_i  (req_move),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .outcome_i     (outcome),
    .found_score_i (found_score),
    .found_move_i  (found_move),
    .probe_count_i (probe_count),
    .hit_count_i   (hit_count),
    .cutoff_count_i(cutoff_count),
    .store_count_i (store_count),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  // receiver: stretches of never, seldom, mostly and square-wave stall
  always @(posedge clk) begin
    if (stall_mode_len == 0) begin
      stall_mode     <= $urandom_range(0, 3);
      stall_mode_len <= $urandom_range(16, 160);
    end else begin
      stall_mode_len <= stall_mode_len - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_mode_len[2];
    endcase
  end

  function automatic request_t make_request(input logic [1:0] kind, input logic [KeyW-1:0] key,
                                            input int depth, input int alpha, input int beta,
                                            input int ply, input int score,
                                            input logic [1:0] bound, input int move);
    request_t r;
    r.kind  = kind;
    r.key   = key;
    r.depth = DepthW'(depth);
    r.alpha = ScoreW'(alpha);
    r.beta  = ScoreW'(beta);
    r.ply   = PlyW'(ply);
    r.score = ScoreW'(score);
    r.bound = bound;
    r.move  = InMoveW'(move);
    return r;
  endfunction

  // scores biased toward the mate edges and the saturation limits
  function automatic logic signed [ScoreW-1:0] pick_score();
    case ($urandom_range(0, 11))
      0: return ScoreW'(900000);
      1: return ScoreW'(900001);
      2: return ScoreW'(-900000);
      3: return ScoreW'(-900001);
      4: return ScoreW'(1048575);
      5: return ScoreW'(-1048575);
      6: return ScoreW'(-1048576);  // the pattern below the score range
      7: return ScoreW'(900000 + $urandom_range(1, 300));
      8: return ScoreW'(-900000 - $urandom_range(1, 300));
      default: return ScoreW'($urandom);
    endcase
  endfunction

  function automatic logic signed [ScoreW-1:0] pick_window();
    case ($urandom_range(0, 4))
      0: return ScoreW'(1048575);
      1: return ScoreW'(-1048575);
      2: return ScoreW'(int'($urandom_range(0, 2000)) - 1000);
      default: return ScoreW'($urandom);
    endcase
  endfunction

  // mostly probes and stores on a small key pool crowded into a few buckets,
  // so that hits, way-1 hits and evictions are common; the rest is noise
  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick    = $urandom_range(0, 999);
    r.kind  = KIND_PROBE;
    r.key   = key_pool[$urandom_range(0, PoolSize-1)];
    r.depth = DepthW'($urandom);
    r.alpha = pick_window();
    r.beta  = pick_window();
    r.ply   = PlyW'($urandom);
    r.score = pick_score();
    r.bound = 2'($urandom);
    r.move  = InMoveW'($urandom);
    if (pick < 470) begin
      r.kind = KIND_PROBE;
    end else if (pick < 850) begin
      r.kind = KIND_STORE;
    end else if (pick < 920) begin
      r.kind = 2'($urandom_range(0, 1));
      r.key  = {$urandom, $urandom};
    end else if (pick < 950) begin
      r.kind = 2'($urandom_range(0, 1));
      r.key  = '0;
    end else if (pick < 993) begin
      r.kind = KindUnused;
    end else begin
      r.kind = KIND_CLEAR;
    end
    return r;
  endfunction

  // offer one word and hold it until taken; bursts end in a random gap
  task automatic send_word(input request_t w);
    req_kind  <= w.kind;
    req_key   <= w.key;
    req_depth <= w.depth;
    req_alpha <= w.alpha;
    req_beta  <= w.beta;
    req_ply   <= w.ply;
    req_score <= w.score;
    req_bound <= w.bound;
    req_move  <= w.move;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
  endtask

  // watchdog: allows the clearing pass, every clear and worst-case stalls many times over
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    hot_rows[0] = '0;
    hot_rows[1] = '1;
    for (int r = 2; r < HotRows; r++) begin
      hot_rows[r] = BucketIndexBitsDef'($urandom);
    end
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][BucketIndexBitsDef-1:0] = hot_rows[i % HotRows];
      if (key_pool[i] == '0) begin
        key_pool[i][KeyW-1] = 1'b1;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero key, unused kind
    send_word(make_request(KIND_PROBE, '0, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
    send_word(make_request(KIND_STORE, '0, 9, 0, 0, 3, 5, BOUND_EXACT, 16'h1234));
    send_word(make_request(KindUnused, KeyA, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
    // saturated mate score in, pulled back by the probe ply
    send_word(make_request(KIND_STORE, KeyA, 255, 0, 0, 255, 1048575, BOUND_EXACT, 16'hFFFF));
    send_word(make_request(KIND_PROBE, KeyA, 255, 0, 0, 255, 0, BOUND_EXACT, 0));
    // below-range score pattern as a lower bound; cutoff and move-only hit
    send_word(make_request(KIND_STORE, KeyB, 10, 0, 0, 7, -1048576, BOUND_LOWER, 0));
    send_word(make_request(KIND_PROBE, KeyB, 10, 0, -1048575, 0, 0, BOUND_EXACT, 0));
    send_word(make_request(KIND_PROBE, KeyB, 10, 0, 1048575, 0, 0, BOUND_EXACT, 0));
    // first key now sits in way 1; too shallow a stored depth
    send_word(make_request(KIND_PROBE, KeyA, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
    send_word(make_request(KIND_PROBE, KeyB, 11, 0, -1048575, 0, 0, BOUND_EXACT, 0));
    // third key in the bucket evicts the first; upper bound both ways
    send_word(make_request(KIND_STORE, KeyC, 5, 0, 0, 100, 900001, BOUND_UPPER, 16'h5A5A));
    send_word(make_request(KIND_PROBE, KeyA, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
    send_word(make_request(KIND_PROBE, KeyC, 5, 1048575, 0, 50, 0, BOUND_EXACT, 0));
    send_word(make_request(KIND_PROBE, KeyC, 0, -1048575, 0, 50, 0, BOUND_EXACT, 0));
    // bound type three never cuts off; mate edges on both signs
    send_word(make_request(KIND_STORE, KeyD, 3, 0, 0, 200, 900000, BoundUnused, 1));
    send_word(make_request(KIND_PROBE, KeyD, 0, 1048575, -1048575, 200, 0, BOUND_EXACT, 0));
    send_word(make_request(KIND_STORE, KeyE, 7, 0, 0, 1, -900001, BOUND_EXACT, 16'h8000));
    send_word(make_request(KIND_PROBE, KeyE, 7, 0, 0, 255, 0, BOUND_EXACT, 0));
    send_word(make_request(KIND_STORE, KeyF, 0, 0, 0, 9, -900000, BOUND_LOWER, 16'h00FF));
    send_word(make_request(KIND_PROBE, KeyF, 0, 0, -1048575, 9, 0, BOUND_EXACT, 0));
    // clear wipes entries and counters
    send_word(make_request(KIND_CLEAR, '0, 0, 0, 0, 0, 0, BOUND_EXACT, 0));
    send_word(make_request(KIND_PROBE, KeyC, 0, 0, 0, 0, 0, BOUND_EXACT, 0));

    for (int n = 0; n < RandomWords; n++) begin
      send_word(random_request());
    end
    in_valid <= 1'b0;

    // drain, then give late or extra result words a chance to show up
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
